>>> src/cpca_pkg.sv
package cpca_pkg;

   // fixed field widths
   localparam int COORD_W = 16;
   localparam int AREA_W  = 38;

   // smallest polygon that is checked, default largest
   localparam int MIN_VERTICES     = 4;
   localparam int MAX_VERTICES_DEF = 8;

   // depth of the beat queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // width of a vertex count that can hold max + 1
   function automatic int count_width(input int max_vertices);
      return $clog2(max_vertices + 2);
   endfunction

   // width of one queued vertex beat: x, y, last, store flag, count
   function automatic int beat_width(input int max_vertices);
      return 2 * COORD_W + 2 + count_width(max_vertices);
   endfunction

endpackage

>>> src/cpca_front.sv
module cpca_front
   import cpca_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [COORD_W-1:0]           in_x,
   input  logic signed [COORD_W-1:0]           in_y,
   input  logic                                in_last,
   input  logic                                q_ready,
   output logic                                q_push,
   output logic [beat_width(MAX_VERTICES)-1:0] q_data
);

   localparam int CW = count_width(MAX_VERTICES);

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      last;
      logic                      store;
      logic [CW-1:0]             cnt;
   } beat_type;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] cnt_next;
   beat_type      beat;

   // vertex count saturates one above the limit
   always_comb begin
      cnt_next = (cnt_ff <= CW'(MAX_VERTICES)) ? cnt_ff + CW'(1) : cnt_ff;
      cnt_in   = cnt_ff;
      if (q_push) begin
         cnt_in = in_last ? '0 : cnt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // classify the beat: store slot, running count, closing flag
   always_comb begin
      beat.x     = in_x;
      beat.y     = in_y;
      beat.last  = in_last;
      beat.store = cnt_ff < CW'(MAX_VERTICES);
      beat.cnt   = cnt_next;
   end

   assign q_push = in_valid & q_ready;
   assign q_data = beat;

endmodule

>>> src/cpca_queue.sv
module cpca_queue
   import cpca_pkg::*;
#(
   parameter int WIDTH = beat_width(MAX_VERTICES_DEF)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wp_ff, wp_in;
   logic [PW-1:0]    rp_ff, rp_in;
   logic [PW:0]      fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = fill_ff != (PW+1)'(QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = slot_ff[rp_ff];
   assign do_push    = push & push_ready;
   assign do_pop     = pop & pop_valid;

   // pointer and fill update
   always_comb begin
      wp_in   = do_push ? wp_ff + PW'(1) : wp_ff;
      rp_in   = do_pop ? rp_ff + PW'(1) : rp_ff;
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (PW+1)'(1);
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         fill_ff <= fill_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wp_ff] <= push_data;
      end
   end

endmodule

>>> src/cpca_back.sv
module cpca_back
   import cpca_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  logic [beat_width(MAX_VERTICES)-1:0] q_data,
   output logic                                q_pop,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic                                out_convex,
   output logic [AREA_W-1:0]                   out_area,
   output logic                                out_error
);

   localparam int CW    = count_width(MAX_VERTICES);
   localparam int AW    = $clog2(MAX_VERTICES);
   localparam int DW    = COORD_W + 1;
   localparam int PW    = 2 * DW;
   localparam int TW    = PW + 1;
   localparam int VW    = 2 * COORD_W;
   localparam int SW    = VW + 1;
   localparam int ACC_W = SW + $clog2(MAX_VERTICES) + 1;

   localparam logic [1:0] S_LOAD  = 2'd0;
   localparam logic [1:0] S_WALK  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_FIN   = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      last;
      logic                      store;
      logic [CW-1:0]             cnt;
   } beat_type;

   beat_type beat;
   assign beat = q_data;

   // vertex store
   logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
   logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] n_ff, n_in;
   logic          err_ff, err_in;
   logic [CW-1:0] j_ff, j_in;
   logic [AW-1:0] raddr_ff, raddr_in;
   logic          rd_en;
   logic          start_walk;
   logic          out_free;
   logic          bad_count;

   // walk pipeline
   logic                      rv_ff, s1v_ff, s2v_ff;
   logic [CW-1:0]             rj_ff, s1j_ff, s2j_ff;
   logic signed [COORD_W-1:0] rd_x_ff, rd_y_ff, pv_x_ff, pv_y_ff;
   logic signed [DW-1:0]      d_x_ff, d_y_ff, dp_x_ff, dp_y_ff;
   logic signed [VW-1:0]      mxy_ff, myx_ff;
   logic signed [PW-1:0]      t1_ff, t2_ff;
   logic signed [SW-1:0]      sh_ff;
   logic                      sh_en_ff, tn_en_ff;
   logic signed [TW-1:0]      turn;
   logic                      pos_ff, neg_ff, zero_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic [ACC_W-1:0]          acc_abs;
   logic [ACC_W+AREA_W-1:0]   area_ext;
   logic                      convex;

   logic                      out_valid_ff, out_valid_in;
   logic                      out_convex_ff;
   logic [AREA_W-1:0]         out_area_ff;
   logic                      out_error_ff;

   assign q_pop     = (state_ff == S_LOAD) & q_valid;
   assign bad_count = (beat.cnt < CW'(MIN_VERTICES)) | (beat.cnt > CW'(MAX_VERTICES));
   assign out_free  = !out_valid_ff | out_ready;
   assign rd_en     = state_ff == S_WALK;
   assign start_walk = q_pop & beat.last & !bad_count;

   // sequencer: load vertices, walk the ring, deliver the result
   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      err_in   = err_ff;
      j_in     = j_ff;
      raddr_in = raddr_ff;
      case (state_ff)
         S_LOAD: begin
            if (q_pop && beat.last) begin
               n_in     = beat.cnt;
               err_in   = bad_count;
               j_in     = '0;
               raddr_in = '0;
               state_in = bad_count ? S_FIN : S_WALK;
            end
         end
         S_WALK: begin
            j_in     = j_ff + CW'(1);
            raddr_in = (CW'(raddr_ff) == n_ff - CW'(1)) ? '0 : raddr_ff + AW'(1);
            if (j_ff == n_ff + CW'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (s2v_ff && s2j_ff == n_ff + CW'(1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
      n_ff     <= n_in;
      err_ff   <= err_in;
      j_ff     <= j_in;
      raddr_ff <= raddr_in;
   end

   // vertex store write and registered read
   always_ff @(posedge clock) begin
      if (q_pop && beat.store) begin
         mem_x[AW'(beat.cnt - CW'(1))] <= beat.x;
         mem_y[AW'(beat.cnt - CW'(1))] <= beat.y;
      end
      if (rd_en) begin
         rd_x_ff <= mem_x[raddr_ff];
         rd_y_ff <= mem_y[raddr_ff];
      end
   end

   // pipeline valids and ring positions
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff  <= 1'b0;
         s1v_ff <= 1'b0;
         s2v_ff <= 1'b0;
      end else begin
         rv_ff  <= rd_en;
         s1v_ff <= rv_ff;
         s2v_ff <= s1v_ff;
      end
      rj_ff  <= j_ff;
      s1j_ff <= rj_ff;
      s2j_ff <= s1j_ff;
   end

   // stage 1: edge deltas and shoelace products of neighbor vertices
   always_ff @(posedge clock) begin
      if (rv_ff) begin
         pv_x_ff <= rd_x_ff;
         pv_y_ff <= rd_y_ff;
         d_x_ff  <= DW'(rd_x_ff) - DW'(pv_x_ff);
         d_y_ff  <= DW'(rd_y_ff) - DW'(pv_y_ff);
         mxy_ff  <= pv_x_ff * rd_y_ff;
         myx_ff  <= rd_x_ff * pv_y_ff;
      end
   end

   // stage 2: turn products of consecutive edges, shoelace term
   always_ff @(posedge clock) begin
      if (s1v_ff) begin
         dp_x_ff  <= d_x_ff;
         dp_y_ff  <= d_y_ff;
         t1_ff    <= dp_x_ff * d_y_ff;
         t2_ff    <= d_x_ff * dp_y_ff;
         sh_ff    <= SW'(mxy_ff) - SW'(myx_ff);
         sh_en_ff <= (s1j_ff >= CW'(1)) & (s1j_ff <= n_ff);
         tn_en_ff <= s1j_ff >= CW'(2);
      end
   end

   // stage 3: turn sign flags and area sum
   assign turn = TW'(t1_ff) - TW'(t2_ff);

   always_ff @(posedge clock) begin
      if (start_walk) begin
         pos_ff  <= 1'b0;
         neg_ff  <= 1'b0;
         zero_ff <= 1'b0;
         acc_ff  <= '0;
      end else if (s2v_ff) begin
         if (tn_en_ff) begin
            if (turn == '0) begin
               zero_ff <= 1'b1;
            end else if (turn[TW-1]) begin
               neg_ff <= 1'b1;
            end else begin
               pos_ff <= 1'b1;
            end
         end
         if (sh_en_ff) begin
            acc_ff <= acc_ff + ACC_W'(sh_ff);
         end
      end
   end

   // result register
   assign convex   = !err_ff & !zero_ff & !(pos_ff & neg_ff);
   assign acc_abs  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign area_ext = {{AREA_W{1'b0}}, acc_abs};

   always_comb begin
      out_valid_in = out_valid_ff;
      if (state_ff == S_FIN && out_free) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (state_ff == S_FIN && out_free) begin
         out_convex_ff <= convex;
         out_area_ff   <= convex ? area_ext[AREA_W-1:0] : '0;
         out_error_ff  <= err_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_convex = out_convex_ff;
   assign out_area   = out_area_ff;
   assign out_error  = out_error_ff;

   // checks
   a_area_only_convex: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_convex_ff |-> out_area_ff == '0)
      else $error("area given for a polygon that is not convex");

   a_error_not_convex: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_error_ff |-> !out_convex_ff)
      else $error("count error reported as convex");

   a_pipe_in_walk: assert property (@(posedge clock) disable iff (reset)
      s2v_ff |-> state_ff == S_WALK || state_ff == S_DRAIN)
      else $error("walk pipeline busy outside the walk");

   a_read_in_ring: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> CW'(raddr_ff) < n_ff)
      else $error("vertex read beyond the loaded ring");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN && out_free |=> out_valid_ff)
      else $error("finished polygon gave no result");

endmodule

>>> src/convex_polygon_check_area.sv
// Convex polygon check and twice-area. Vertices stream in one per beat on req_, in ring
// order, with req_tlast on the closing vertex; each closing beat yields one rsp_ beat.
// The input side takes one beat per cycle into a 4-deep queue whenever there is room, even
// while a result waits on rsp_. The back end loads queued vertices one per cycle into its
// vertex store, then walks the ring through the single read port of that store, reading
// n + 2 vertices for a polygon of n, drains the multiplier pipeline and registers the
// result; it loads no vertex of the next polygon before that. A polygon with fewer
// than 4 or more than MAX_VERTICES vertices skips the walk and reports count_error
// after its last vertex is loaded. Convexity needs every turn nonzero and of one sign;
// twice_area is the magnitude of the shoelace sum, and zero when not convex.
module convex_polygon_check_area
   import cpca_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // vertex beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // coord_x [15:0], coord_y [31:16]
   input  logic        req_tlast,   // last_vertex
   // result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // twice_area [37:0], zero [39:38]
   output logic [1:0]  rsp_tuser    // is_convex [0], count_error [1]
);

   localparam int BW = beat_width(MAX_VERTICES);

   logic          q_push, q_ready, q_pop, q_valid;
   logic [BW-1:0] push_data, pop_data;
   logic          out_convex, out_error;
   logic [AREA_W-1:0] out_area;

   // front: count and classify vertex beats
   cpca_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_x     (req_tdata[COORD_W-1:0]),
      .in_y     (req_tdata[2*COORD_W-1:COORD_W]),
      .in_last  (req_tlast),
      .q_ready  (q_ready),
      .q_push   (q_push),
      .q_data   (push_data)
   );

   // queue between front and back
   cpca_queue #(.WIDTH(BW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (push_data),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (pop_data)
   );

   // back: store, walk, result
   cpca_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (pop_data),
      .q_pop      (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_convex (out_convex),
      .out_area   (out_area),
      .out_error  (out_error)
   );

   assign req_tready = q_ready;
   assign rsp_tdata  = {2'b00, out_area};
   assign rsp_tuser  = {out_error, out_convex};

endmodule

>>> tb/tb_top.sv
module tb_top;
   import cpca_pkg::*;

   localparam int RANDOM_VERTICES = 1300;
   localparam int QUIET_LIMIT     = 3000;
   localparam int DRAIN_CYCLES    = 40;

   // one vertex beat as sent on req_
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      last;
   } vertex_type;

   // one result beat as expected on rsp_
   typedef struct packed {
      logic              is_convex;
      logic [AREA_W-1:0] twice_area;
      logic              count_error;
   } poly_result_type;

   // directed row: vertex, whether the result is typed in, and that result
   typedef struct packed {
      vertex_type      vtx;
      logic            typed;
      poly_result_type want;
   } directed_row_type;

   localparam poly_result_type NO_RESULT          = '0;
   localparam poly_result_type NOT_CONVEX_RESULT  = '0;
   localparam poly_result_type COUNT_ERROR_RESULT = '{1'b0, '0, 1'b1};
   localparam poly_result_type FULL_SQUARE_RESULT = '{1'b1, 38'd8589672450, 1'b0};

   localparam directed_row_type DIRECTED [25] = '{
      // too few: three vertices
      '{'{16'sd0, 16'sd0, 1'b0}, 1'b0, NO_RESULT},
      '{'{16'sd10, 16'sd0, 1'b0}, 1'b0, NO_RESULT},
      '{'{16'sd0, 16'sd10, 1'b1}, 1'b1, COUNT_ERROR_RESULT},
      // square over the full coordinate range
      '{'{16'sh8000, 16'sh8000, 1'b0}, 1'b0, NO_RESULT},
      '{'{16'sh7FFF, 16'sh8000, 1'b0}, 1'b0, NO_RESULT},
      '{'{16'sh7FFF, 16'sh7FFF, 1'b0}, 1'b0, NO_RESULT},
      '{'{16'sh8000, 16'sh7FFF, 1'b1}, 1'b1, FULL_SQUARE_RESULT},
      // three collinear vertices give a zero turn
      '{'{16'sd0, 16'sd0, 1'b0}, 1'b0, NO_RESULT},
      '{'{16'sd1, 16'sd0, 1'b0}, 1'b0, NO_RESULT},
      '{'{16'sd2, 16'sd0, 1'b0}, 1'b0, NO_RESULT},
      '{'{16'sd0, 16'sd1, 1'b1}, 1'b1, NOT_CONVEX_RESULT},
      // pentagram: self-crossing, every turn of one sign
      '{'{16'sd0, 16'sd100, 1'b0}, 1'b0, NO_RESULT},
      '{'{16'sd59, -16'sd81, 1'b0}, 1'b0, NO_RESULT},
      '{'{-16'sd95, 16'sd31, 1'b0}, 1'b0, NO_RESULT},
      '{'{16'sd95, 16'sd31, 1'b0}, 1'b0, NO_RESULT},
      '{'{-16'sd59, -16'sd81, 1'b1}, 1'b0, NO_RESULT},
      // too many: nine vertices
      '{'{16'sd1, 16'sd2, 1'b0}, 1'b0, NO_RESULT},
      '{'{-16'sd3, 16'sd4, 1'b0}, 1'b0, NO_RESULT},
      '{'{16'sd5, -16'sd6, 1'b0}, 1'b0, NO_RESULT},
      '{'{16'sd7, 16'sd8, 1'b0}, 1'b0, NO_RESULT},
      '{'{-16'sd9, -16'sd10, 1'b0}, 1'b0, NO_RESULT},
      '{'{16'sd11, 16'sd12, 1'b0}, 1'b0, NO_RESULT},
      '{'{16'sd13, -16'sd14, 1'b0}, 1'b0, NO_RESULT},
      '{'{-16'sd15, 16'sd16, 1'b0}, 1'b0, NO_RESULT},
      '{'{16'sd17, 16'sd18, 1'b1}, 1'b1, COUNT_ERROR_RESULT}
   };

   // sixteen directions of radius 1000, counterclockwise
   localparam int DIR_X [16] = '{1000, 924, 707, 383, 0, -383, -707, -924,
                                 -1000, -924, -707, -383, 0, 383, 707, 924};
   localparam int DIR_Y [16] = '{0, 383, 707, 924, 1000, 924, 707, 383,
                                 0, -383, -707, -924, -1000, -924, -707, -383};

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // coord_x [15:0], coord_y [31:16]
   logic        req_tlast  = 1'b0; // last_vertex
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // twice_area [37:0], zero [39:38]
   logic [1:0]  rsp_tuser;         // is_convex [0], count_error [1]

   int vertex_gap_pct   = 24;
   int result_stall_pct = 46;
   int mismatch_count   = 0;
   int quiet_cycles     = 0;

   poly_result_type area_expect_q [$];

   // predictor state: vertices of the open polygon and how many so far
   logic signed [COORD_W-1:0] ring_x [MAX_VERTICES_DEF];
   logic signed [COORD_W-1:0] ring_y [MAX_VERTICES_DEF];
   int ring_count = 0;

   convex_polygon_check_area dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // cross product of (b - a) and (c - b)
   function automatic longint turn_at(input int a, input int b, input int c);
      longint dx1, dy1, dx2, dy2;
      dx1 = longint'(ring_x[b]) - longint'(ring_x[a]);
      dy1 = longint'(ring_y[b]) - longint'(ring_y[a]);
      dx2 = longint'(ring_x[c]) - longint'(ring_x[b]);
      dy2 = longint'(ring_y[c]) - longint'(ring_y[b]);
      return dx1 * dy2 - dx2 * dy1;
   endfunction

   // take one vertex; returns 1 with the result when it closes a polygon
   function automatic bit take_vertex(input vertex_type v, output poly_result_type res);
      int     n;
      longint t;
      longint area_sum;
      bit     pos, neg, flat;
      res      = '0;
      pos      = 1'b0;
      neg      = 1'b0;
      flat     = 1'b0;
      area_sum = 0;
      if (ring_count < MAX_VERTICES_DEF) begin
         ring_x[ring_count] = v.x;
         ring_y[ring_count] = v.y;
      end
      if (ring_count <= MAX_VERTICES_DEF) ring_count++;
      if (!v.last) return 1'b0;
      n = ring_count;
      ring_count = 0;
      if (n < MIN_VERTICES || n > MAX_VERTICES_DEF) begin
         res.count_error = 1'b1;
         return 1'b1;
      end
      // turn at every vertex, wrapping around the ring
      for (int i = 0; i < n; i++) begin
         t = turn_at((i == 0) ? n - 1 : i - 1, i, (i + 1 == n) ? 0 : i + 1);
         if (t > 0) pos = 1'b1;
         else if (t < 0) neg = 1'b1;
         else flat = 1'b1;
      end
      if (flat || (pos && neg)) return 1'b1;
      // shoelace sum
      for (int i = 0; i < n; i++) begin
         area_sum += longint'(ring_x[i]) * longint'(ring_y[(i + 1) % n])
                   - longint'(ring_x[(i + 1) % n]) * longint'(ring_y[i]);
      end
      if (area_sum < 0) area_sum = -area_sum;
      res.is_convex  = 1'b1;
      res.twice_area = area_sum[AREA_W-1:0];
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned want,
                                  input longint unsigned got);
      $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $time);
      mismatch_count++;
   endtask

   // drive one vertex beat, wait for its handshake, then predict
   task automatic send_vertex(input vertex_type v, input bit typed,
                              input poly_result_type want);
      poly_result_type predicted;
      while ($urandom_range(99) < vertex_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {v.y, v.x};
      req_tlast  <= v.last;
      do @(posedge clock); while (!req_tready);
      if (take_vertex(v, predicted)) area_expect_q.push_back(typed ? want : predicted);
   endtask

   // result beat checks, receiver stalls and the no-progress watchdog
   always @(posedge clock) begin : result_check
      poly_result_type oldest;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (area_expect_q.size() == 0) begin
               report_mismatch("result with none pending", 0, rsp_tdata);
            end else begin
               oldest = area_expect_q.pop_front();
               if (rsp_tuser[0] !== oldest.is_convex)
                  report_mismatch("is_convex", oldest.is_convex, rsp_tuser[0]);
               if (rsp_tdata[AREA_W-1:0] !== oldest.twice_area)
                  report_mismatch("twice_area", oldest.twice_area, rsp_tdata[AREA_W-1:0]);
               if (rsp_tuser[1] !== oldest.count_error)
                  report_mismatch("count_error", oldest.count_error, rsp_tuser[1]);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("no beat accepted for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
         end else begin
            quiet_cycles++;
         end
      end
      rsp_tready <= ($urandom_range(99) >= result_stall_pct);
   end

   initial begin
      vertex_type v;
      vertex_type poly_q [$];
      int      pick [$];
      int      kind, n, scale, reach, cx, cy, need, spin, flip, d, dup_at;
      int      vertices_sent;
      bit      tiny;
      vertices_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      foreach (DIRECTED[r]) send_vertex(DIRECTED[r].vtx, DIRECTED[r].typed, DIRECTED[r].want);

      // random polygons
      while (vertices_sent < RANDOM_VERTICES) begin
         if (vertices_sent < RANDOM_VERTICES / 3) begin
            vertex_gap_pct   = 24;
            result_stall_pct = 46;
         end else if (vertices_sent < 2 * RANDOM_VERTICES / 3) begin
            vertex_gap_pct   = 46;
            result_stall_pct = 24;
         end else begin
            vertex_gap_pct   = 0;
            result_stall_pct = 0;
         end
         poly_q.delete();
         v.last = 1'b0;
         kind = $urandom_range(99);
         if (kind < 65) begin
            // convex ring: ordered subset of the directions, scaled and shifted
            n     = $urandom_range(MAX_VERTICES_DEF, MIN_VERTICES);
            scale = $urandom_range(32, 1);
            reach = 32767 - 1000 * scale;
            cx    = int'($urandom_range(2 * reach)) - reach;
            cy    = int'($urandom_range(2 * reach)) - reach;
            pick.delete();
            need = n;
            for (int k = 0; k < 16; k++) begin
               if ($urandom_range(15 - k) < need) begin
                  pick.push_back(k);
                  need--;
               end
            end
            spin = $urandom_range(n - 1);
            flip = $urandom_range(1);
            for (int k = 0; k < n; k++) begin
               d   = pick[(spin + (flip ? n - k : k)) % n];
               v.x = 16'(cx + DIR_X[d] * scale);
               v.y = 16'(cy + DIR_Y[d] * scale);
               poly_q.push_back(v);
            end
            // a repeated vertex leaves a zero turn
            if (kind >= 55 && n < MAX_VERTICES_DEF) begin
               dup_at = $urandom_range(n - 1);
               poly_q.insert(dup_at, poly_q[dup_at]);
            end
         end else begin
            // noise: full range, tiny range, or a count out of bounds
            tiny = (kind >= 78 && kind < 88);
            if (kind < 88) n = $urandom_range(MAX_VERTICES_DEF, MIN_VERTICES);
            else if ($urandom_range(1)) n = $urandom_range(MIN_VERTICES - 1, 1);
            else n = $urandom_range(MAX_VERTICES_DEF + 4, MAX_VERTICES_DEF + 1);
            for (int k = 0; k < n; k++) begin
               v.x = tiny ? 16'(int'($urandom_range(6)) - 3) : 16'($urandom_range(65535));
               v.y = tiny ? 16'(int'($urandom_range(6)) - 3) : 16'($urandom_range(65535));
               poly_q.push_back(v);
            end
         end
         poly_q[poly_q.size() - 1].last = 1'b1;
         foreach (poly_q[k]) send_vertex(poly_q[k], 1'b0, NO_RESULT);
         vertices_sent += poly_q.size();
      end
      req_tvalid <= 1'b0;

      // drain, then give late or extra beats a chance to show
      while (area_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
